>>> rtl/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

   // Fixed field widths of the channels
   localparam int REQ_INDEX_W     = 10;
   localparam int REQ_VALUE_W     = 32;
   localparam int RSP_INDEX_W     = 10;
   localparam int CFG_COUNT_W     = 11;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 11;

   // Default sizing
   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_KEY_WIDTH   = 32;

   // Item function codes
   localparam logic FUNC_WRITE    = 1'b0;
   localparam logic FUNC_SEARCH   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE = 1'b1;

   // Key memory port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage : stbs_pkg

`default_nettype wire

>>> rtl/stbs_key_mem.sv
`default_nettype none

module stbs_key_mem
   import stbs_pkg::*;
#(
   parameter int DEPTH  = DEF_TABLE_DEPTH,
   parameter int DATA_W = DEF_KEY_WIDTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire mem_ctl_type       ctl,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data_ff
);

   // Single-port table, registered read data
   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

endmodule : stbs_key_mem

`default_nettype wire

>>> rtl/stbs_search_ctrl.sv
`default_nettype none

module stbs_search_ctrl
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
   localparam int ADDR_W     = $clog2(TABLE_DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_func,
   input  wire logic [REQ_INDEX_W-1:0] req_index,
   input  wire logic [REQ_VALUE_W-1:0] req_value,
   // response
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic      [RSP_INDEX_W-1:0] rsp_match_index,
   // configuration
   input  wire logic [CFG_COUNT_W-1:0] entry_count,
   input  wire logic                   signed_mode,
   // key memory
   output mem_ctl_type                 mem_ctl,
   output logic      [ADDR_W-1:0]      mem_addr,
   output logic      [KEY_WIDTH-1:0]   mem_wr_data,
   input  wire logic [KEY_WIDTH-1:0]   mem_rd_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;
   localparam int SUM_W = CNT_W + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     low_ff, low_in;
   logic [CNT_W-1:0]     high_ff, high_in;
   logic [ADDR_W-1:0]    probe_ff, probe_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [RSP_INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic                 accept;
   logic [CNT_W-1:0]     count_sat;
   logic [KEY_WIDTH-1:0] sign_mask;
   logic [KEY_WIDTH-1:0] entry_ord;
   logic [KEY_WIDTH-1:0] key_ord;
   logic [CNT_W-1:0]     probe_w;
   logic [CNT_W-1:0]     probe_p1;
   logic [SUM_W-1:0]     sum_first;
   logic [SUM_W-1:0]     sum_gt;
   logic [SUM_W-1:0]     sum_lt;
   logic                 slot_free;
   logic                 index_ok;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign count_sat = (CMP_W'(entry_count) > CMP_W'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);
   assign index_ok  = CMP_W'(req_index) < CMP_W'(TABLE_DEPTH);

   // Signed order maps onto unsigned order by flipping the sign bit
   assign sign_mask = signed_mode ? (KEY_WIDTH'(1) << (KEY_WIDTH - 1)) : '0;
   assign entry_ord = mem_rd_data ^ sign_mask;
   assign key_ord   = key_ff ^ sign_mask;

   assign probe_w   = CNT_W'(probe_ff);
   assign probe_p1  = probe_w + CNT_W'(1);
   assign sum_first = SUM_W'(count_sat);
   assign sum_gt    = SUM_W'(low_ff) + SUM_W'(probe_w);
   assign sum_lt    = SUM_W'(probe_p1) + SUM_W'(high_ff);

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      probe_in     = probe_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      mem_ctl      = '0;
      mem_addr     = ADDR_W'(req_index);
      mem_wr_data  = KEY_WIDTH'(req_value);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_WRITE) begin
                  mem_ctl.wr_en = index_ok;
               end else begin
                  key_in  = KEY_WIDTH'(req_value);
                  low_in  = '0;
                  high_in = count_sat;
                  hit_in  = 1'b0;
                  if (count_sat != '0) begin
                     probe_in     = ADDR_W'(sum_first >> 1);
                     mem_addr     = ADDR_W'(sum_first >> 1);
                     mem_ctl.rd_en = 1'b1;
                     state_in     = ST_PROBE;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_PROBE: begin
            // entry of the last probe is on the read port; issue the next one now
            if (entry_ord > key_ord) begin
               high_in = probe_w;
               if (probe_w > low_ff) begin
                  probe_in      = ADDR_W'(sum_gt >> 1);
                  mem_addr      = ADDR_W'(sum_gt >> 1);
                  mem_ctl.rd_en = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (entry_ord < key_ord) begin
               low_in = probe_p1;
               if (high_ff > probe_p1) begin
                  probe_in      = ADDR_W'(sum_lt >> 1);
                  mem_addr      = ADDR_W'(sum_lt >> 1);
                  mem_ctl.rd_en = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               hit_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_index_in = hit_ff ? RSP_INDEX_W'(probe_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      probe_ff     <= probe_in;
      key_ff       <= key_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;

endmodule : stbs_search_ctrl

`default_nettype wire

>>> rtl/sorted_table_binary_search.sv
// Sorted-table binary search.
// Request channel (req_*): func selects a write item (store value at index)
// or a search item (look for value). Writes beyond the table are dropped.
// Response channel (rsp_*): one item per search, none per write: found and
// the matching index (zero when nothing matched).
// Config channel (csr_*): index 0 is entry_count, index 1 is signed_mode;
// ready outside reset, write only while no search is in flight.
// A write item goes into the key memory when it is taken. A search reads
// the key memory once per probe, up to ceil(log2(count+1)) probes with the
// count saturated at the table depth: the first read is issued when the
// search is taken, each probe issues the next, then the result is posted.
// A finished result sits in the output register; the next item may be
// taken while it waits. If the receiver stalls, a following search holds
// its result internally and accepts nothing more until the slot frees.
// Reset clears the control state and config registers; table contents are
// undefined until written.
`default_nettype none

module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_func,
   input  wire logic [REQ_INDEX_W-1:0] req_index,
   input  wire logic [REQ_VALUE_W-1:0] req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic      [RSP_INDEX_W-1:0] rsp_match_index,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [CFG_COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic                   signed_mode_ff, signed_mode_in;

   mem_ctl_type            mem_ctl;
   logic [ADDR_W-1:0]      mem_addr;
   logic [KEY_WIDTH-1:0]   mem_wr_data;
   logic [KEY_WIDTH-1:0]   mem_rd_data;

   // Config registers
   assign csr_ready = !reset;

   always_comb begin
      entry_count_in = entry_count_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENTRY_COUNT: entry_count_in = CFG_COUNT_W'(csr_wdata);
            CSR_SIGNED_MODE: signed_mode_in = csr_wdata[0];
            default: begin
               entry_count_in = entry_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         signed_mode_ff <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   // Search sequencer: one probe per cycle against the key memory
   stbs_search_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_index       (req_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .entry_count     (entry_count_ff),
      .signed_mode     (signed_mode_ff),
      .mem_ctl         (mem_ctl),
      .mem_addr        (mem_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_data     (mem_rd_data)
   );

   // Key table
   stbs_key_mem #(
      .DEPTH  (TABLE_DEPTH),
      .DATA_W (KEY_WIDTH)
   ) u_mem (
      .clock      (clock),
      .ctl        (mem_ctl),
      .addr       (mem_addr),
      .wr_data    (mem_wr_data),
      .rd_data_ff (mem_rd_data)
   );

endmodule : sorted_table_binary_search

`default_nettype wire

>>> dv/tb_top.sv
module tb_top;
   import stbs_pkg::*;

   // Sizing follows the block's defaults
   localparam int DEPTH           = DEF_TABLE_DEPTH;
   localparam int MAX_COUNT       = (1 << CFG_COUNT_W) - 1;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int CALM_TAIL       = 250;
   // Long enough for the worst search plus a trailing write item
   localparam int SETTLE_CYCLES   = 16;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 400_000;
   localparam logic [REQ_VALUE_W-1:0] SIGN_BIT = 32'h8000_0000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One line of the directed stimulus. A CSR row keeps the register index
   // in index and the write data in value. A pinned row carries its
   // expected result instead of asking the lookup model.
   typedef struct packed {
      row_kind_type            kind;
      logic                    func;
      logic [REQ_INDEX_W-1:0]  index;
      logic [REQ_VALUE_W-1:0]  value;
      logic                    pinned;
      logic                    found;
      logic [RSP_INDEX_W-1:0]  match_index;
   } stim_row_type;

   typedef struct packed {
      logic                    found;
      logic [RSP_INDEX_W-1:0]  match_index;
   } lookup_type;

   // DUT ports; every input has a known value from time zero
   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   wire                     req_ready;
   logic                    req_func  = FUNC_WRITE;
   logic [REQ_INDEX_W-1:0]  req_index = '0;
   logic [REQ_VALUE_W-1:0]  req_value = '0;
   wire                     rsp_valid;
   logic                    rsp_ready = 1'b0;
   wire                     rsp_found;
   wire  [RSP_INDEX_W-1:0]  rsp_match_index;
   logic                    csr_valid = 1'b0;
   wire                     csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_ENTRY_COUNT;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Lookup model: its own copy of the key table and both registers
   logic [REQ_VALUE_W-1:0]  model_keys [DEPTH];
   logic [CFG_COUNT_W-1:0]  model_count  = '0;
   logic                    model_signed = 1'b0;
   lookup_type              pending_lookups [$];

   // Shared between the sender, the receiver and the checker
   logic                    pinned = 1'b0;
   lookup_type              pinned_result = '0;
   bit                      calm = 1'b0;
   int                      gap_pct = 0;
   int                      stall_pct = 0;
   bit                      hold_off_req = 1'b0;
   int                      mismatches = 0;
   int                      cycles = 0;

   sorted_table_binary_search u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Lookup model: the classic halving loop over [0, count). The count
   // saturates at the table depth. Signed mode flips the sign bit on both
   // sides so a plain unsigned compare gives two's complement order. The
   // first probe that lands on an equal key wins, so with duplicates the
   // reported index is wherever the halving happens to hit first.
   // ---------------------------------------------------------------------
   function automatic lookup_type lookup_key(input logic [REQ_VALUE_W-1:0] key);
      int unsigned            lo;
      int unsigned            hi;
      int unsigned            probe;
      logic [REQ_VALUE_W-1:0] flip;
      logic [REQ_VALUE_W-1:0] target;
      logic [REQ_VALUE_W-1:0] entry;
      lookup_type             res;
      flip   = model_signed ? SIGN_BIT : '0;
      target = key ^ flip;
      lo     = 0;
      hi     = (int'(model_count) > DEPTH) ? DEPTH : int'(model_count);
      res    = '0;
      while (lo < hi) begin
         probe = (lo + hi) / 2;
         entry = model_keys[probe] ^ flip;
         if (entry > target) begin
            hi = probe;
         end else if (entry < target) begin
            lo = probe + 1;
         end else begin
            res.found       = 1'b1;
            res.match_index = RSP_INDEX_W'(probe);
            break;
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("[%0d] check failed: %s", cycles, what);
   endtask

   // ---------------------------------------------------------------------
   // Monitors, all sampling at the rising edge
   // ---------------------------------------------------------------------

   // Register writes land in the model when the handshake completes
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENTRY_COUNT: begin
               model_count = csr_wdata[CFG_COUNT_W-1:0];
            end
            CSR_SIGNED_MODE: begin
               model_signed = csr_wdata[0];
            end
            default: ;
         endcase
      end
   end

   // Request side: a write item updates the table (the 10-bit index never
   // reaches past the depth), a search item queues its expected result.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (req_func == FUNC_WRITE) begin
            model_keys[req_index] = req_value;
         end else if (pinned) begin
            pending_lookups.push_back(pinned_result);
         end else begin
            pending_lookups.push_back(lookup_key(req_value));
         end
      end
   end

   // Result side: compare field by field against the oldest expectation
   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            note_mismatch($sformatf("unexpected result found=%0b index=%0d",
                                    rsp_found, rsp_match_index));
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_found !== want.found) begin
               note_mismatch($sformatf("found is %0b, want %0b",
                                       rsp_found, want.found));
            end
            if (rsp_match_index !== want.match_index) begin
               note_mismatch($sformatf("match_index is %0d, want %0d",
                                       rsp_match_index, want.match_index));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, none once calm.
   // On request it holds off for a long stretch so the block backs up and
   // drops req_ready while the sender keeps offering.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      static int stall_left = 0;
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (hold_off_req) begin
         hold_off_req = 1'b0;
         rsp_ready   <= 1'b0;
         stall_left   = HOLD_OFF_CYCLES - 1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left  = $urandom_range(0, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Sender. Called at a falling edge, returns at the falling edge after
   // the item is taken. req_valid stays high between back-to-back items;
   // a gap burst lowers it first.
   // ---------------------------------------------------------------------
   task automatic push_item(input logic func, input logic [REQ_INDEX_W-1:0] index,
                            input logic [REQ_VALUE_W-1:0] value);
      int gap;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         gap        = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_index <= index;
      req_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   // Registers change only with the block idle: every result back, then
   // enough cycles for a trailing write item to retire.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic stim_row_type item_row(input logic func, input int index,
                                             input logic [REQ_VALUE_W-1:0] value);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_ITEM;
      row.func  = func;
      row.index = REQ_INDEX_W'(index);
      row.value = value;
      return row;
   endfunction

   function automatic stim_row_type known_search(input logic [REQ_VALUE_W-1:0] value,
                                                 input logic found, input int where);
      stim_row_type row;
      row             = item_row(FUNC_SEARCH, 0, value);
      row.pinned      = 1'b1;
      row.found       = found;
      row.match_index = RSP_INDEX_W'(where);
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] index,
                                            input int data);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = REQ_INDEX_W'(index);
      row.value = REQ_VALUE_W'(data);
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type           rows [$];
      logic [REQ_VALUE_W-1:0] planned [DEPTH];  // what the stimulus has stored
      int                     order [DEPTH];
      int                     random_items;
      int                     phase;
      int                     count;
      int                     reach;
      int                     n_keys;
      int                     n_search;
      int                     pick;
      int                     swap;
      int                     j;
      int                     r;
      bit                     refill;
      logic                   mode;
      logic [REQ_VALUE_W-1:0] flip;
      logic [REQ_VALUE_W-1:0] v;
      logic [REQ_INDEX_W-1:0] idx;
      longint unsigned        ordered;
      longint unsigned        step_max;

      // Directed: reset state, key extremes in both compare modes,
      // duplicate keys, a one-entry table and a zero count over real data.
      rows.push_back(known_search(32'h0000_0000, 1'b0, 0));   // count 0 after reset
      rows.push_back(known_search(32'hFFFF_FFFF, 1'b0, 0));
      rows.push_back(item_row(FUNC_WRITE, 0, 32'h0000_0000));
      rows.push_back(item_row(FUNC_WRITE, 1, 32'h0000_0005));
      rows.push_back(item_row(FUNC_WRITE, 2, 32'h8000_0000));
      rows.push_back(item_row(FUNC_WRITE, 3, 32'hFFFF_FFFF));
      rows.push_back(csr_row(CSR_ENTRY_COUNT, 4));
      rows.push_back(known_search(32'h0000_0000, 1'b1, 0));   // lowest key
      rows.push_back(known_search(32'hFFFF_FFFF, 1'b1, 3));   // highest key
      rows.push_back(item_row(FUNC_SEARCH, 0, 32'h0000_0005));
      rows.push_back(known_search(32'h0000_0003, 1'b0, 0));   // falls between keys
      rows.push_back(csr_row(CSR_SIGNED_MODE, 1));
      rows.push_back(item_row(FUNC_WRITE, 0, 32'h8000_0000));
      rows.push_back(item_row(FUNC_WRITE, 1, 32'hFFFF_FFFF));
      rows.push_back(item_row(FUNC_WRITE, 2, 32'h0000_0000));
      rows.push_back(item_row(FUNC_WRITE, 3, 32'h7FFF_FFFF));
      rows.push_back(known_search(32'h8000_0000, 1'b1, 0));   // most negative
      rows.push_back(known_search(32'h7FFF_FFFF, 1'b1, 3));   // most positive
      rows.push_back(item_row(FUNC_SEARCH, 0, 32'hFFFF_FFFF));
      rows.push_back(known_search(32'h0000_0001, 1'b0, 0));
      rows.push_back(csr_row(CSR_SIGNED_MODE, 0));
      rows.push_back(item_row(FUNC_WRITE, 0, 32'h0000_0007));
      rows.push_back(item_row(FUNC_WRITE, 1, 32'h0000_0007));
      rows.push_back(item_row(FUNC_WRITE, 2, 32'h0000_0007));
      rows.push_back(item_row(FUNC_WRITE, 3, 32'h0000_0007));
      rows.push_back(item_row(FUNC_SEARCH, 0, 32'h0000_0007));   // duplicates
      rows.push_back(csr_row(CSR_ENTRY_COUNT, 1));
      rows.push_back(known_search(32'h0000_0007, 1'b1, 0));
      rows.push_back(csr_row(CSR_ENTRY_COUNT, 0));
      rows.push_back(known_search(32'h0000_0007, 1'b0, 0));   // data present, count 0

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            write_csr(rows[i].index[CSR_INDEX_W-1:0], rows[i].value[CSR_DATA_W-1:0]);
         end else begin
            pinned        = rows[i].pinned;
            pinned_result = '{found: rows[i].found, match_index: rows[i].match_index};
            push_item(rows[i].func, rows[i].index, rows[i].value);
            if (rows[i].func == FUNC_WRITE) begin
               planned[rows[i].index] = rows[i].value;
            end
            pinned = 1'b0;
         end
      end

      // Random phases. Each sets both registers; all but phases 2 and 3 fill
      // [0, count) with keys ascending in the chosen order (written in shuffled
      // order, a few stray writes past the count), then each mostly searches for
      // keys that are present, a few for near misses and some for random values.
      // Phase 1 fills the whole table and triggers the long receiver
      // hold-off. Phase 2 searches it with the count at its maximum,
      // phase 3 flips the compare mode over the same data, so the table
      // is out of order for the halving loop. Searches never reach an
      // entry that was not written.
      random_items = 0;
      phase        = 0;
      mode         = 1'b0;
      while (random_items < RANDOM_ITEMS || phase < 5) begin
         calm      = (random_items > RANDOM_ITEMS - CALM_TAIL);
         r         = $urandom_range(0, 2);
         gap_pct   = (r == 0) ? 0 : (r == 1) ? 15 : 40;
         r         = $urandom_range(0, 2);
         stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;
         refill    = 1'b1;
         case (phase)
            1: begin
               mode  = $urandom_range(0, 1);
               count = DEPTH;
            end
            2: begin
               count  = MAX_COUNT;
               refill = 1'b0;
            end
            3: begin
               mode   = !mode;
               count  = $urandom_range(DEPTH + 1, MAX_COUNT - 1);
               refill = 1'b0;
            end
            default: begin
               mode = $urandom_range(0, 1);
               r    = $urandom_range(0, 9);
               if (r == 0) begin
                  count = 0;
               end else if (r == 1) begin
                  count = (1 << $urandom_range(0, 6)) + $urandom_range(0, 2) - 1;
                  if (count == 0) count = 1;
               end else begin
                  count = $urandom_range(1, 40);
               end
            end
         endcase
         write_csr(CSR_SIGNED_MODE, {CSR_DATA_W'($urandom_range(0, 1023)) << 1} | mode);
         write_csr(CSR_ENTRY_COUNT, CSR_DATA_W'(count));
         reach = (count > DEPTH) ? DEPTH : count;
         flip  = mode ? SIGN_BIT : '0;

         if (refill) begin
            n_keys   = reach;
            ordered  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1 << 20);
            step_max = (n_keys > 0) ? (64'hFFFF_FFFF - ordered) / n_keys : 1;
            for (int i = 0; i < n_keys; i++) begin
               planned[i] = REQ_VALUE_W'(ordered) ^ flip;
               ordered   += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, step_max);
               order[i]   = i;
            end
            for (int i = n_keys - 1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               swap     = order[i];
               order[i] = order[j];
               order[j] = swap;
            end
            for (int i = 0; i < n_keys; i++) begin
               push_item(FUNC_WRITE, REQ_INDEX_W'(order[i]), planned[order[i]]);
               random_items++;
            end
            if (n_keys < DEPTH) begin
               repeat ($urandom_range(0, 3)) begin
                  idx          = REQ_INDEX_W'($urandom_range(n_keys, DEPTH - 1));
                  v            = $urandom;
                  planned[idx] = v;
                  push_item(FUNC_WRITE, idx, v);
                  random_items++;
               end
            end
         end

         if (phase == 1) hold_off_req = 1'b1;

         n_search = $urandom_range(20, 60);
         repeat (n_search) begin
            r    = $urandom_range(0, 9);
            pick = (reach > 0) ? $urandom_range(0, reach - 1) : 0;
            if (reach > 0 && r < 6) begin
               v = planned[pick];
            end else if (reach > 0 && r < 8) begin
               v = planned[pick] + (($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF);
            end else begin
               v = $urandom;
            end
            push_item(FUNC_SEARCH, REQ_INDEX_W'($urandom_range(0, DEPTH - 1)), v);
            random_items++;
         end
         phase++;
      end

      // Drain
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/stbs_pkg.sv
rtl/stbs_key_mem.sv
rtl/stbs_search_ctrl.sv
rtl/sorted_table_binary_search.sv
dv/tb_top.sv
